@@ src/gs_pkg.sv @@
package gs_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [7:0] CFG_SYSTEM_SIZE     = 8'd0;
    localparam logic [7:0] CFG_PIVOT_THRESHOLD = 8'd1;

    typedef struct packed {
        logic signed [31:0] coef_value;
        logic               last_element;
    } gs_in_t;

    typedef struct packed {
        logic signed [31:0] solution_value;
        logic [2:0]         solution_index;
        logic               singular;
        logic               last_result;
    } gs_out_t;

    typedef enum logic [0:0] {
        ALU_MUL,
        ALU_DIV
    } gs_alu_op_t;

    typedef struct packed {
        logic       start;
        gs_alu_op_t op;
    } gs_alu_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_SW_RJ,
        ST_SW_RK,
        ST_SW_WJ,
        ST_SW_WK,
        ST_EL_RD_IJ,
        ST_EL_RD_JJ,
        ST_EL_DIV,
        ST_EL_DIV_WAIT,
        ST_EL_RD_JC,
        ST_EL_MUL,
        ST_EL_MUL_WAIT,
        ST_EL_RD_IC,
        ST_EL_WR_IC,
        ST_LAST_RD,
        ST_LAST_CHK,
        ST_BS_RD_KC,
        ST_BS_MUL,
        ST_BS_MUL_WAIT,
        ST_BS_RD_B,
        ST_BS_RD_KK,
        ST_BS_DIV,
        ST_BS_DIV_WAIT,
        ST_OUT_LD,
        ST_OUT,
        ST_SING
    } gs_state_t;

endpackage

@@ src/gs_alu.sv @@
module gs_alu #(
    parameter int W = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gs_pkg::gs_alu_req_t req,
    input  logic signed [W-1:0] opa,
    input  logic signed [W-1:0] opb,
    output logic                done,
    output logic signed [W-1:0] result
);
    import gs_pkg::*;

    localparam int CNTW = $clog2(W + FRAC_BITS + 1);
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    logic             busy_reg, busy_next;
    gs_alu_op_t       op_reg, op_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             aneg_reg, aneg_next;
    logic             dz_reg, dz_next;
    logic             az_reg, az_next;
    logic [2*W-1:0]   p_reg, p_next;
    logic [W-1:0]     y_reg, y_next;
    logic [W:0]       rem_reg, rem_next;
    logic             done_reg, done_next;
    logic [W-1:0]     result_reg, result_next;

    logic [W-1:0]     ua, ub, mag_a, mag_b;
    logic [W:0]       sum_m, rem_sh;
    logic             ge;
    logic [2*W-1:0]   q;
    logic             big;

    assign ua    = opa;
    assign ub    = opb;
    assign mag_a = ua[W-1] ? (~ua + W'(1)) : ua;
    assign mag_b = ub[W-1] ? (~ub + W'(1)) : ub;

    // shift-add step for multiply, restoring step for divide
    assign sum_m  = {1'b0, p_reg[2*W-1:W]} + (p_reg[0] ? {1'b0, y_reg} : '0);
    assign rem_sh = {rem_reg[W-1:0], p_reg[W+FRAC_BITS-1]};
    assign ge     = rem_sh >= {1'b0, y_reg};

    assign q   = (op_reg == ALU_MUL) ? {{FRAC_BITS{1'b0}}, p_reg[2*W-1:FRAC_BITS]} : p_reg;
    assign big = |q[2*W-1:W-1];

    always_comb begin
        busy_next   = busy_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        aneg_next   = aneg_reg;
        dz_next     = dz_reg;
        az_next     = az_reg;
        p_next      = p_reg;
        y_next      = y_reg;
        rem_next    = rem_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = (req.op == ALU_MUL) ? CNTW'(W) : CNTW'(W + FRAC_BITS);
            neg_next  = ua[W-1] ^ ub[W-1];
            aneg_next = ua[W-1];
            dz_next   = (mag_b == '0);
            az_next   = (mag_a == '0);
            y_next    = mag_b;
            rem_next  = '0;
            p_next    = (req.op == ALU_MUL) ? {{W{1'b0}}, mag_a}
                                            : (2*W)'({mag_a, {FRAC_BITS{1'b0}}});
        end else if (busy_reg && cnt_reg != '0) begin
            cnt_next = cnt_reg - CNTW'(1);
            if (op_reg == ALU_MUL) begin
                p_next = {sum_m, p_reg[W-1:1]};
            end else begin
                rem_next = ge ? (rem_sh - {1'b0, y_reg}) : rem_sh;
                p_next   = (2*W)'({p_reg[W+FRAC_BITS-2:0], ge});
            end
        end else if (busy_reg) begin
            busy_next = 1'b0;
            done_next = 1'b1;
            if (op_reg == ALU_DIV && dz_reg) begin
                result_next = az_reg ? '0 : (aneg_reg ? VMIN : VMAX);
            end else if (neg_reg) begin
                result_next = big ? VMIN : (~q[W-1:0] + W'(1));
            end else begin
                result_next = big ? VMAX : q[W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        aneg_reg   <= aneg_next;
        dz_reg     <= dz_next;
        az_reg     <= az_next;
        p_reg      <= p_next;
        y_reg      <= y_next;
        rem_reg    <= rem_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ src/gs_seq.sv @@
module gs_seq #(
    parameter int M = 8,
    parameter int W = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [$clog2(M+1)-1:0]                n_in,
    input  logic [15:0]                           thr,
    input  logic                                  ld_we,
    input  logic [$clog2(M*(M+1))-1:0]            ld_addr,
    input  logic signed [W-1:0]                   ld_data,
    output logic                                  idle,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output gs_pkg::gs_out_t                       m_item
);
    import gs_pkg::*;

    localparam int CW    = $clog2(M + 1);
    localparam int DEPTH = M * (M + 1);
    localparam int MAW   = $clog2(DEPTH);
    localparam int AXW   = 2 * CW + 2;
    localparam int IW    = $clog2(M);
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    gs_state_t         state_reg, state_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     c_reg, c_next;
    logic signed [W-1:0] t_reg, t_next;
    logic signed [W-1:0] f_reg, f_next;
    logic signed [W-1:0] sum_reg, sum_next;
    logic signed [W-1:0] sol_reg [M];
    logic              sol_we;
    logic              out_valid_reg, out_valid_next;
    gs_out_t           out_reg, out_next;

    logic [W-1:0]      mem [DEPTH];
    logic signed [W-1:0] rd_reg;
    logic              mem_re, seq_we;
    logic [W-1:0]      seq_wdata;
    logic [CW-1:0]     row_sel, col_sel;
    logic [AXW-1:0]    addr_full;
    logic [MAW-1:0]    seq_addr;

    gs_alu_req_t       alu_req;
    logic signed [W-1:0] alu_a, alu_b, alu_res;
    logic              alu_done;

    logic [W-1:0]      rd_u, rd_mag;
    logic              piv_small;
    logic signed [W-1:0] sub_b;
    logic [W:0]        diff, addv;
    logic signed [W-1:0] sub_sat, add_sat;
    logic [CW-1:0]     sol_idx;
    logic signed [W-1:0] sol_rd;
    logic signed [63:0]  sol64;
    logic [7:0]        k8;
    logic [CW:0]       i_inc, c_inc, j_inc2, n_ext;

    gs_alu #(.W(W)) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_a),
        .opb     (alu_b),
        .done    (alu_done),
        .result  (alu_res)
    );

    assign addr_full = AXW'(row_sel) * (AXW'(n_reg) + AXW'(1)) + AXW'(col_sel);
    assign seq_addr  = MAW'(addr_full);

    always_ff @(posedge aclk) begin
        if (ld_we) begin
            mem[ld_addr] <= ld_data;
        end else if (seq_we) begin
            mem[seq_addr] <= seq_wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[seq_addr];
        end
    end

    assign rd_u      = rd_reg;
    assign rd_mag    = rd_u[W-1] ? (~rd_u + W'(1)) : rd_u;
    assign piv_small = rd_mag <= W'(thr);

    // saturating subtract, shared by elimination and back-substitution, and saturating add for back-substitution
    assign sub_b   = (state_reg == ST_EL_WR_IC) ? t_reg : sum_reg;
    assign diff    = {rd_reg[W-1], rd_reg} - {sub_b[W-1], sub_b};
    assign sub_sat = (diff[W] != diff[W-1]) ? (diff[W] ? VMIN : VMAX) : diff[W-1:0];
    assign addv    = {sum_reg[W-1], sum_reg} + {alu_res[W-1], alu_res};
    assign add_sat = (addv[W] != addv[W-1]) ? (addv[W] ? VMIN : VMAX) : addv[W-1:0];

    assign sol_idx = (state_reg == ST_OUT_LD) ? k_reg : c_reg;
    assign sol_rd  = sol_reg[sol_idx[IW-1:0]];
    assign sol64   = 64'(sol_rd);
    assign k8      = 8'(k_reg);

    assign i_inc  = {1'b0, i_reg} + (CW+1)'(1);
    assign c_inc  = {1'b0, c_reg} + (CW+1)'(1);
    assign j_inc2 = {1'b0, j_reg} + (CW+1)'(2);
    assign n_ext  = {1'b0, n_reg};

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        c_next         = c_reg;
        t_next         = t_reg;
        f_next         = f_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sol_we         = 1'b0;
        mem_re         = 1'b0;
        seq_we         = 1'b0;
        seq_wdata      = rd_reg;
        row_sel        = j_reg;
        col_sel        = c_reg;
        alu_req.start  = 1'b0;
        alu_req.op     = ALU_MUL;
        alu_a          = t_reg;
        alu_b          = rd_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    n_next     = n_in;
                    j_next     = '0;
                    k_next     = CW'(1);
                    state_next = (n_in > CW'(1)) ? ST_PIV_RD : ST_LAST_RD;
                end
            end
            ST_PIV_RD: begin
                mem_re     = 1'b1;
                col_sel    = j_reg;
                state_next = ST_PIV_CHK;
            end
            ST_PIV_CHK: begin
                if (!piv_small) begin
                    i_next     = j_reg + CW'(1);
                    state_next = ST_EL_RD_IJ;
                end else if (k_reg < n_reg) begin
                    c_next     = '0;
                    state_next = ST_SW_RJ;
                end else begin
                    state_next = ST_SING;
                end
            end
            ST_SW_RJ: begin
                mem_re     = 1'b1;
                state_next = ST_SW_RK;
            end
            ST_SW_RK: begin
                mem_re     = 1'b1;
                row_sel    = k_reg;
                t_next     = rd_reg;
                state_next = ST_SW_WJ;
            end
            ST_SW_WJ: begin
                seq_we     = 1'b1;
                state_next = ST_SW_WK;
            end
            ST_SW_WK: begin
                seq_we    = 1'b1;
                seq_wdata = t_reg;
                row_sel   = k_reg;
                if (c_reg == n_reg) begin
                    k_next     = k_reg + CW'(1);
                    state_next = ST_PIV_RD;
                end else begin
                    c_next     = c_reg + CW'(1);
                    state_next = ST_SW_RJ;
                end
            end
            ST_EL_RD_IJ: begin
                mem_re     = 1'b1;
                row_sel    = i_reg;
                col_sel    = j_reg;
                state_next = ST_EL_RD_JJ;
            end
            ST_EL_RD_JJ: begin
                mem_re     = 1'b1;
                col_sel    = j_reg;
                t_next     = rd_reg;
                state_next = ST_EL_DIV;
            end
            ST_EL_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                state_next    = ST_EL_DIV_WAIT;
            end
            ST_EL_DIV_WAIT: begin
                if (alu_done) begin
                    f_next     = alu_res;
                    c_next     = j_reg + CW'(1);
                    state_next = ST_EL_RD_JC;
                end
            end
            ST_EL_RD_JC: begin
                mem_re     = 1'b1;
                state_next = ST_EL_MUL;
            end
            ST_EL_MUL: begin
                alu_req.start = 1'b1;
                alu_a         = f_reg;
                state_next    = ST_EL_MUL_WAIT;
            end
            ST_EL_MUL_WAIT: begin
                if (alu_done) begin
                    t_next     = alu_res;
                    state_next = ST_EL_RD_IC;
                end
            end
            ST_EL_RD_IC: begin
                mem_re     = 1'b1;
                row_sel    = i_reg;
                state_next = ST_EL_WR_IC;
            end
            ST_EL_WR_IC: begin
                seq_we    = 1'b1;
                seq_wdata = sub_sat;
                row_sel   = i_reg;
                if (c_reg != n_reg) begin
                    c_next     = c_reg + CW'(1);
                    state_next = ST_EL_RD_JC;
                end else if (i_inc < n_ext) begin
                    i_next     = i_inc[CW-1:0];
                    state_next = ST_EL_RD_IJ;
                end else if (j_inc2 < n_ext) begin
                    j_next     = j_reg + CW'(1);
                    k_next     = j_inc2[CW-1:0];
                    state_next = ST_PIV_RD;
                end else begin
                    state_next = ST_LAST_RD;
                end
            end
            ST_LAST_RD: begin
                mem_re     = 1'b1;
                row_sel    = n_reg - CW'(1);
                col_sel    = n_reg - CW'(1);
                state_next = ST_LAST_CHK;
            end
            ST_LAST_CHK: begin
                if (piv_small) begin
                    state_next = ST_SING;
                end else begin
                    k_next     = n_reg - CW'(1);
                    c_next     = n_reg;
                    sum_next   = '0;
                    state_next = ST_BS_RD_B;
                end
            end
            ST_BS_RD_KC: begin
                mem_re     = 1'b1;
                row_sel    = k_reg;
                state_next = ST_BS_MUL;
            end
            ST_BS_MUL: begin
                alu_req.start = 1'b1;
                alu_a         = rd_reg;
                alu_b         = sol_rd;
                state_next    = ST_BS_MUL_WAIT;
            end
            ST_BS_MUL_WAIT: begin
                if (alu_done) begin
                    sum_next = add_sat;
                    if (c_inc < n_ext) begin
                        c_next     = c_inc[CW-1:0];
                        state_next = ST_BS_RD_KC;
                    end else begin
                        state_next = ST_BS_RD_B;
                    end
                end
            end
            ST_BS_RD_B: begin
                mem_re     = 1'b1;
                row_sel    = k_reg;
                col_sel    = n_reg;
                state_next = ST_BS_RD_KK;
            end
            ST_BS_RD_KK: begin
                mem_re     = 1'b1;
                row_sel    = k_reg;
                col_sel    = k_reg;
                t_next     = sub_sat;
                state_next = ST_BS_DIV;
            end
            ST_BS_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                state_next    = ST_BS_DIV_WAIT;
            end
            ST_BS_DIV_WAIT: begin
                if (alu_done) begin
                    sol_we = 1'b1;
                    if (k_reg == '0) begin
                        k_next     = n_reg - CW'(1);
                        state_next = ST_OUT_LD;
                    end else begin
                        sum_next   = '0;
                        c_next     = k_reg;
                        k_next     = k_reg - CW'(1);
                        state_next = ST_BS_RD_KC;
                    end
                end
            end
            ST_OUT_LD: begin
                out_next.solution_value = (sol64 > 64'sd2147483647) ? 32'sh7fffffff :
                                          (sol64 < -64'sd2147483648) ? 32'sh80000000 :
                                          sol64[31:0];
                out_next.solution_index = k8[2:0];
                out_next.singular       = 1'b0;
                out_next.last_result    = (k_reg == '0);
                out_valid_next          = 1'b1;
                state_next              = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    out_valid_next = 1'b0;
                    if (k_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg - CW'(1);
                        state_next = ST_OUT_LD;
                    end
                end
            end
            ST_SING: begin
                out_next.solution_value = '0;
                out_next.solution_index = '0;
                out_next.singular       = 1'b1;
                out_next.last_result    = 1'b1;
                out_valid_next          = 1'b1;
                k_next                  = '0;
                state_next              = ST_OUT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        n_reg   <= n_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        i_reg   <= i_next;
        c_reg   <= c_next;
        t_reg   <= t_next;
        f_reg   <= f_next;
        sum_reg <= sum_next;
        out_reg <= out_next;
        if (sol_we) begin
            sol_reg[k_reg[IW-1:0]] <= alu_res;
        end
    end

    assign idle    = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

`ifndef ASSERT_OFF
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> state_reg == ST_OUT)
        else $error("result valid outside output state");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_we |-> state_reg == ST_IDLE)
        else $error("load write while solving");
    a_sing_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.singular |-> out_reg.last_result)
        else $error("singular report not marked last");
    a_last_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && m_ready && out_reg.last_result |=> !out_valid_reg && idle)
        else $error("run did not end after last transfer");
`endif

endmodule

@@ src/linear_system_gauss_solver.sv @@
// Loading: one element per cycle; s_ready is high while no solve is running.
// Solving after the last element is paced by the single bit-serial multiply/divide unit
// and by the store accesses around each multiply and divide.
// Results: n transfers (or one singular report); each is held until m_ready takes it.
// Reset (aresetn low, synchronous) sets control state, load position and config registers
// to defaults (size 8, threshold 7); datapath registers and stores stay undefined.
module linear_system_gauss_solver #(
    parameter int MAX_UNKNOWNS = 8,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  gs_pkg::gs_in_t  s_item,
    output logic            m_valid,
    input  logic            m_ready,
    output gs_pkg::gs_out_t m_item,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import gs_pkg::*;

    localparam int M     = MAX_UNKNOWNS;
    localparam int W     = VALUE_WIDTH;
    localparam int CW    = $clog2(M + 1);
    localparam int DEPTH = M * (M + 1);
    localparam int MAW   = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);

    logic [3:0]     size_reg, size_next;
    logic [15:0]    thr_reg, thr_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  n_cur;
    logic [PW-1:0]  lim;
    logic           s_fire, ld_we, seq_idle;
    logic signed [63:0] in64, vmax64, vmin64;
    logic signed [63:0] clamped;
    logic signed [W-1:0] ld_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = seq_idle;
    assign s_fire    = s_valid && s_ready;

    assign n_cur = (size_reg == '0) ? CW'(1) :
                   (32'(size_reg) > M) ? CW'(M) : CW'(size_reg);
    assign lim   = PW'(32'(n_cur) * (32'(n_cur) + 32'd1));

    // clamp the 32-bit input to the internal word
    assign in64    = 64'(s_item.coef_value);
    assign vmax64  = (64'sd1 <<< (W - 1)) - 64'sd1;
    assign vmin64  = -vmax64 - 64'sd1;
    assign clamped = (in64 > vmax64) ? vmax64 : (in64 < vmin64) ? vmin64 : in64;
    assign ld_data = clamped[W-1:0];

    assign ld_we = s_fire && (pos_reg < lim);

    always_comb begin
        size_next = size_reg;
        thr_next  = thr_reg;
        pos_next  = pos_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SYSTEM_SIZE:     size_next = cfg_data[3:0];
                CFG_PIVOT_THRESHOLD: thr_next  = cfg_data[15:0];
                default:             ;
            endcase
        end
        if (ld_we) begin
            pos_next = pos_reg + PW'(1);
        end
        if (s_fire && s_item.last_element) begin
            pos_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= 4'd8;
            thr_reg  <= 16'd7;
            pos_reg  <= '0;
        end else begin
            size_reg <= size_next;
            thr_reg  <= thr_next;
            pos_reg  <= pos_next;
        end
    end

    gs_seq #(.M(M), .W(W)) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_fire && s_item.last_element),
        .n_in    (n_cur),
        .thr     (thr_reg),
        .ld_we   (ld_we),
        .ld_addr (MAW'(pos_reg)),
        .ld_data (ld_data),
        .idle    (seq_idle),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
